// ===== design/adf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Audio DMA FIFO package
// Shared types, codes and constants for the audio DMA two-entry queue.
// ----------------------------------------------------------------------------
package adf_pkg;

  localparam int MemAddrBits = 23;
  localparam int DivW        = 50;
  localparam int DvsW        = 32;
  localparam int PaddrW      = 5;

  localparam logic [1:0] MODE_WRITE   = 2'd0;
  localparam logic [1:0] MODE_TICK    = 2'd1;
  localparam logic [1:0] MODE_READ    = 2'd2;
  localparam logic [1:0] MODE_REQUEUE = 2'd3;

  localparam logic [2:0] REG_DAC_CLOCK  = 3'd0;
  localparam logic [2:0] REG_DAC_RATE   = 3'd1;
  localparam logic [2:0] REG_FRAME_TIME = 3'd2;
  localparam logic [2:0] REG_FPS        = 3'd3;
  localparam logic [2:0] REG_FULL_EN    = 3'd4;

  localparam logic [26:0] DAC_CLOCK_RST  = 27'd48681812;
  localparam logic [13:0] DAC_RATE_RST   = 14'd0;
  localparam logic [23:0] FRAME_TIME_RST = 24'd500000;
  localparam logic [7:0]  FPS_RST        = 8'd60;
  localparam logic        FULL_EN_RST    = 1'b1;

  localparam logic [17:0] LEN_MAX = 18'h3FFFF;

  typedef struct packed {
    logic [1:0]  mode;
    logic [23:0] dram_address;
    logic [17:0] byte_length;
  } in_t;

  typedef struct packed {
    logic        dma_start;
    logic [22:0] dma_address;
    logic [17:0] dma_length;
    logic        interrupt_raise;
    logic        timer_expired;
    logic        busy_flag;
    logic        full_flag;
    logic [17:0] remaining_length;
  } out_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RATE_START,
    S_RATE_WAIT,
    S_MUL1,
    S_MUL2,
    S_NUM_START,
    S_NUM_WAIT,
    S_REM_MUL,
    S_REM_START,
    S_REM_WAIT,
    S_COMMIT
  } state_t;

endpackage

// ===== design/adf_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Audio DMA FIFO divider
// Restoring divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module adf_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [adf_pkg::DivW-1:0]  dividend,
  input  logic [adf_pkg::DvsW-1:0]  divisor,
  output logic                      done,
  output logic [adf_pkg::DivW-1:0]  quotient
);
  import adf_pkg::*;

  localparam int CntW = $clog2(DivW);

  logic [DivW-1:0] quo;
  logic [DvsW-1:0] rem;
  logic [DvsW-1:0] dvs;
  logic [CntW-1:0] cnt;
  logic            run;
  logic [DvsW:0]   sh;
  logic [DvsW:0]   diff;
  logic            ge;

  assign sh       = {rem, quo[DivW-1]};
  assign diff     = sh - {1'b0, dvs};
  assign ge       = sh >= {1'b0, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 1'b1;
        if (cnt == CntW'(DivW - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (run) begin
      quo <= {quo[DivW-2:0], ge};
      rem <= ge ? diff[DvsW-1:0] : sh[DvsW-1:0];
    end
  end

endmodule

// ===== design/audio_dma_two_entry_fifo_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Audio DMA two-entry FIFO core
// DMA start control with a two-entry transfer queue and a countdown timer.
// ----------------------------------------------------------------------------
// Items enter on the in channel (valid/ready) and each produces one result
// item on the out channel (valid/ready). Configuration registers sit on an
// APB-style port at byte addresses 0, 4, 8, 12 and 16; the user must write
// them only while the block is idle, which the block itself does not enforce.
// The block works on one item at a time and is not ready meanwhile. A read
// that needs a quotient makes one pass, and a length write or, with full_en
// set, a timer requeue makes up to two, through one shared restoring divider
// that yields one quotient bit per cycle (first the sample rate, then the
// duration). Multiplications are registered steps.
// The result is held in an output register; when the receiver stalls, the
// finished item waits there and the next item is accepted, but its result
// is not written until the register is free.
// Reset clears the queue, the flags and the timer and restores the register
// defaults; no item is pending after reset.
// ----------------------------------------------------------------------------
module audio_dma_two_entry_fifo_core #(
  parameter int MEMORY_ADDRESS_BITS = adf_pkg::MemAddrBits
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  adf_pkg::in_t                in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output adf_pkg::out_t               out_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [adf_pkg::PaddrW-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import adf_pkg::*;

  localparam logic [23:0] AddrMask = 24'((25'd1 << MEMORY_ADDRESS_BITS) - 25'd1);

  logic [26:0] dac_clock;
  logic [13:0] dac_rate;
  logic [23:0] frame_time;
  logic [7:0]  fps;
  logic        full_en;

  state_t state, state_next;
  in_t    item;
  logic [17:0] op_len;
  logic [26:0] rate;
  logic [DivW-1:0] prod;
  logic [31:0] dur;
  logic [17:0] remain;

  logic [23:0] q0_addr, q1_addr, q0_addr_next, q1_addr_next;
  logic [17:0] q0_len, q1_len, q0_len_next, q1_len_next;
  logic [31:0] q0_dur, q1_dur, q0_dur_next, q1_dur_next;
  logic        busy, full, act, busy_next, full_next, act_next;
  logic [31:0] cdown, cdown_next;
  logic [17:0] last_len, last_len_next;
  out_t        res;
  logic        launch, launch_sel;

  logic            div_start, div_done;
  logic [DivW-1:0] div_dvd, div_q;
  logic [DvsW-1:0] div_dvs;
  logic            accept, commit, rem_zero;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      dac_clock  <= DAC_CLOCK_RST;
      dac_rate   <= DAC_RATE_RST;
      frame_time <= FRAME_TIME_RST;
      fps        <= FPS_RST;
      full_en    <= FULL_EN_RST;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[4:2])
        REG_DAC_CLOCK:  dac_clock  <= pwdata[26:0];
        REG_DAC_RATE:   dac_rate   <= pwdata[13:0];
        REG_FRAME_TIME: frame_time <= pwdata[23:0];
        REG_FPS:        fps        <= pwdata[7:0];
        REG_FULL_EN:    full_en    <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_DAC_CLOCK:  prdata = {5'd0, dac_clock};
      REG_DAC_RATE:   prdata = {18'd0, dac_rate};
      REG_FRAME_TIME: prdata = {8'd0, frame_time};
      REG_FPS:        prdata = {24'd0, fps};
      REG_FULL_EN:    prdata = {31'd0, full_en};
      default:        prdata = '0;
    endcase
  end

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign commit   = (state == S_COMMIT) && (!out_valid || out_ready);
  assign rem_zero = (q0_dur == '0) || !act || cdown[31];

  adf_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    div_start = 1'b0;
    div_dvd   = prod;
    div_dvs   = q0_dur;
    unique case (state)
      S_RATE_START: begin
        div_start = 1'b1;
        div_dvd   = {23'd0, dac_clock};
        div_dvs   = {17'd0, 15'(dac_rate) + 15'd1};
      end
      S_NUM_START: begin
        div_start = 1'b1;
        div_dvs   = {3'd0, rate, 2'b00};
      end
      S_REM_START: div_start = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (in_data.mode)
            MODE_WRITE:   state_next = S_RATE_START;
            MODE_TICK:    state_next = S_COMMIT;
            MODE_READ:    state_next = rem_zero ? S_COMMIT : S_REM_MUL;
            MODE_REQUEUE: state_next = full_en ? S_RATE_START : S_COMMIT;
            default:      state_next = S_COMMIT;
          endcase
        end
      end
      S_RATE_START: state_next = S_RATE_WAIT;
      S_RATE_WAIT:  if (div_done) begin
        state_next = (div_q[26:0] == '0) ? S_COMMIT : S_MUL1;
      end
      S_MUL1:       state_next = S_MUL2;
      S_MUL2:       state_next = S_NUM_START;
      S_NUM_START:  state_next = S_NUM_WAIT;
      S_NUM_WAIT:   if (div_done) state_next = S_COMMIT;
      S_REM_MUL:    state_next = S_REM_START;
      S_REM_START:  state_next = S_REM_WAIT;
      S_REM_WAIT:   if (div_done) state_next = S_COMMIT;
      S_COMMIT:     if (commit) state_next = S_IDLE;
      default:      state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item   <= in_data;
      op_len <= (in_data.mode == MODE_WRITE) ? in_data.byte_length : last_len;
      dur    <= '0;
      remain <= '0;
    end
    if (state == S_RATE_WAIT && div_done) begin
      rate <= div_q[26:0];
    end
    if (state == S_MUL1) begin
      prod <= {8'd0, 42'(op_len) * 42'(frame_time)};
    end
    if (state == S_MUL2) begin
      prod <= DivW'(prod[41:0]) * DivW'(fps);
    end
    if (state == S_NUM_WAIT && div_done) begin
      dur <= div_q[31:0];
    end
    if (state == S_REM_MUL) begin
      prod <= {1'b0, 49'(cdown[30:0]) * 49'(q0_len)};
    end
    if (state == S_REM_WAIT && div_done) begin
      remain <= (div_q[31:18] != '0) ? LEN_MAX : div_q[17:0];
    end
  end

  always_comb begin
    q0_addr_next  = q0_addr;
    q0_len_next   = q0_len;
    q0_dur_next   = q0_dur;
    q1_addr_next  = q1_addr;
    q1_len_next   = q1_len;
    q1_dur_next   = q1_dur;
    busy_next     = busy;
    full_next     = full;
    act_next      = act;
    cdown_next    = cdown;
    last_len_next = last_len;
    launch        = 1'b0;
    launch_sel    = 1'b0;
    res           = '0;
    unique case (item.mode)
      MODE_WRITE: begin
        last_len_next = item.byte_length;
        if (busy) begin
          q1_addr_next = item.dram_address;
          q1_len_next  = item.byte_length;
          q1_dur_next  = dur;
          if (full_en) begin
            full_next = 1'b1;
          end else begin
            launch     = 1'b1;
            launch_sel = 1'b1;
          end
        end else begin
          q0_addr_next = item.dram_address;
          q0_len_next  = item.byte_length;
          q0_dur_next  = dur;
          busy_next    = 1'b1;
          launch       = 1'b1;
        end
      end
      MODE_TICK: begin
        if (act) begin
          if (cdown <= 32'd1) begin
            cdown_next        = '0;
            act_next          = 1'b0;
            res.timer_expired = 1'b1;
            if (full) begin
              q0_addr_next = q1_addr;
              q0_len_next  = q1_len;
              q0_dur_next  = q1_dur;
              full_next    = 1'b0;
              launch       = 1'b1;
            end else begin
              busy_next = 1'b0;
            end
          end else begin
            cdown_next = cdown - 32'd1;
          end
        end
      end
      MODE_READ: res.remaining_length = remain;
      MODE_REQUEUE: begin
        cdown_next = full_en ? dur : '0;
        act_next   = full_en;
      end
      default: ;
    endcase
    if (launch) begin
      res.dma_start   = 1'b1;
      res.dma_address = launch_sel ? 23'(q1_addr_next & AddrMask & 24'hFFFFFC)
                                   : 23'(q0_addr_next & AddrMask & 24'hFFFFFC);
      res.dma_length  = launch_sel ? q1_len_next : q0_len_next;
      if (!full_next) begin
        if (full_en) begin
          cdown_next = launch_sel ? q1_dur_next : q0_dur_next;
          act_next   = 1'b1;
        end else begin
          res.interrupt_raise = 1'b1;
        end
      end
    end
    res.busy_flag = busy_next;
    res.full_flag = full_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q0_addr  <= '0;
      q0_len   <= '0;
      q0_dur   <= '0;
      q1_addr  <= '0;
      q1_len   <= '0;
      q1_dur   <= '0;
      busy     <= 1'b0;
      full     <= 1'b0;
      act      <= 1'b0;
      cdown    <= '0;
      last_len <= '0;
    end else if (commit) begin
      q0_addr  <= q0_addr_next;
      q0_len   <= q0_len_next;
      q0_dur   <= q0_dur_next;
      q1_addr  <= q1_addr_next;
      q1_len   <= q1_len_next;
      q1_dur   <= q1_dur_next;
      busy     <= busy_next;
      full     <= full_next;
      act      <= act_next;
      cdown    <= cdown_next;
      last_len <= last_len_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_data <= res;
    end
  end

endmodule

// ===== design/adf_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Audio DMA FIFO checker
// Port-level assertions for the audio DMA core, bound to the top level.
// ----------------------------------------------------------------------------
module adf_checker (
  input logic          clk,
  input logic          rst,
  input logic          out_valid,
  input logic          out_ready,
  input adf_pkg::out_t out_data
);
  import adf_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("A stalled result item was dropped.");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("A result item appeared right after reset.");

  a_idle_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.dma_start |-> out_data.dma_address == '0 &&
      out_data.dma_length == '0)
    else $error("Transfer fields are set without a DMA start.");

  a_full_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.full_flag |-> out_data.busy_flag)
    else $error("Full is reported while the block is not busy.");

endmodule

bind audio_dma_two_entry_fifo_core adf_checker u_adf_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ===== dv/tb_audio_dma_two_entry_fifo_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Audio DMA two-entry FIFO core testbench
// Drives length writes, ticks, reads and requeues through the queue. A local
// copy of the controller state predicts every result. Registers are written
// over the APB port between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_audio_dma_two_entry_fifo_core;
  import adf_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PaddrW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  logic [26:0] cfg_clock;
  logic [13:0] cfg_rate;
  logic [23:0] cfg_frame;
  logic [7:0] cfg_fps;
  logic cfg_full_en;

  logic [23:0] q_addr [2];
  logic [17:0] q_len [2];
  logic [31:0] q_dur [2];
  logic busy, full, cd_active;
  logic [31:0] countdown;
  logic [17:0] last_len;
  out_t pending_res;

  out_t dma_results [$];
  int errors = 0;
  bit drain_hold = 1'b0;
  int hold_cycles = 0;

  audio_dma_two_entry_fifo_core i_dut (.*);

  always #1 clk = ~clk;

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [31:0] duration_of(logic [17:0] len);
    logic [63:0] rate, denom, num;
    rate = 64'(cfg_clock) / (64'(cfg_rate) + 64'd1);
    denom = rate * 64'd4;
    if (denom == 0) return 32'd0;
    num = 64'(len) * 64'(cfg_frame) * 64'(cfg_fps);
    return 32'(num / denom);
  endfunction

  task automatic start_dma(int slot);
    pending_res.dma_start = 1'b1;
    pending_res.dma_address = q_addr[slot][22:0] & 23'(((64'd1 << MemAddrBits) - 1))
                              & ~23'd3;
    pending_res.dma_length = q_len[slot];
    if (!full) begin
      if (cfg_full_en) begin
        countdown = q_dur[slot];
        cd_active = 1'b1;
      end else begin
        pending_res.interrupt_raise = 1'b1;
      end
    end
  endtask

  task automatic predict_dma(in_t it);
    logic [31:0] dur;
    logic [63:0] r;
    pending_res = '0;
    case (it.mode)
      MODE_WRITE: begin
        dur = duration_of(it.byte_length);
        last_len = it.byte_length;
        if (busy) begin
          q_addr[1] = it.dram_address;
          q_len[1] = it.byte_length;
          q_dur[1] = dur;
          if (cfg_full_en) full = 1'b1;
          else start_dma(1);
        end else begin
          q_addr[0] = it.dram_address;
          q_len[0] = it.byte_length;
          q_dur[0] = dur;
          busy = 1'b1;
          start_dma(0);
        end
      end
      MODE_TICK: begin
        if (cd_active) begin
          if (countdown <= 1) begin
            countdown = 0;
            cd_active = 1'b0;
            pending_res.timer_expired = 1'b1;
            if (full) begin
              q_addr[0] = q_addr[1];
              q_len[0] = q_len[1];
              q_dur[0] = q_dur[1];
              full = 1'b0;
              start_dma(0);
            end else begin
              busy = 1'b0;
            end
          end else begin
            countdown = countdown - 1;
          end
        end
      end
      MODE_READ: begin
        if (q_dur[0] != 0 && cd_active && countdown < 32'h8000_0000) begin
          r = 64'(countdown) * 64'(q_len[0]) / 64'(q_dur[0]);
          r = r & 64'hFFFF_FFFF;
          pending_res.remaining_length = (r > 64'(LEN_MAX)) ? LEN_MAX : r[17:0];
        end
      end
      default: begin
        if (cfg_full_en) begin
          countdown = duration_of(last_len);
          cd_active = 1'b1;
        end else begin
          countdown = 0;
          cd_active = 1'b0;
        end
      end
    endcase
    pending_res.busy_flag = busy;
    pending_res.full_flag = full;
    dma_results.push_back(pending_res);
  endtask

  task automatic send_item(in_t it);
    repeat (gap_len() + 1) @(posedge clk);
    predict_dma(it);
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic send_fields(logic [1:0] m, logic [23:0] a, logic [17:0] l);
    in_t it;
    it.mode = m;
    it.dram_address = a;
    it.byte_length = l;
    send_item(it);
  endtask

  task automatic wait_idle();
    while (dma_results.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] v);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= PaddrW'(idx) << 2;
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_DAC_CLOCK: cfg_clock = v[26:0];
      REG_DAC_RATE: cfg_rate = v[13:0];
      REG_FRAME_TIME: cfg_frame = v[23:0];
      REG_FPS: cfg_fps = v[7:0];
      default: cfg_full_en = v[0];
    endcase
    @(posedge clk);
  endtask

  task automatic set_config(logic [26:0] c, logic [13:0] r, logic [23:0] f, logic [7:0] s,
                            logic e);
    wait_idle();
    write_reg(REG_DAC_CLOCK, 32'(c));
    write_reg(REG_DAC_RATE, 32'(r));
    write_reg(REG_FRAME_TIME, 32'(f));
    write_reg(REG_FPS, 32'(s));
    write_reg(REG_FULL_EN, 32'(e));
  endtask

  task automatic test_directed();
    send_fields(MODE_TICK, 24'hFFFFFF, 18'h3FFFF);
    send_fields(MODE_READ, 24'd0, 18'd0);
    send_fields(MODE_WRITE, 24'hFFFFFF, 18'h3FFFF);
    send_fields(MODE_READ, 24'd0, 18'd0);
    send_fields(MODE_WRITE, 24'h000003, 18'd0);
    send_fields(MODE_TICK, 24'd0, 18'd0);
    send_fields(MODE_READ, 24'd0, 18'd0);
    send_fields(MODE_REQUEUE, 24'd0, 18'd0);
    send_fields(MODE_READ, 24'd0, 18'd0);
    set_config(27'd1, 14'd16383, 24'hFFFFFF, 8'd255, 1'b1);
    send_fields(MODE_WRITE, 24'h123457, 18'd100);
    send_fields(MODE_TICK, 24'd0, 18'd0);
    send_fields(MODE_TICK, 24'd0, 18'd0);
    send_fields(MODE_READ, 24'd0, 18'd0);
    set_config(27'd100000000, 14'd0, 24'd0, 8'd1, 1'b0);
    send_fields(MODE_WRITE, 24'hABCDEF, 18'd40);
    send_fields(MODE_WRITE, 24'h800001, 18'h3FFFF);
    send_fields(MODE_REQUEUE, 24'd0, 18'd0);
    send_fields(MODE_TICK, 24'd0, 18'd0);
    send_fields(MODE_READ, 24'd0, 18'd0);
  endtask

  task automatic send_random_item(int short_len);
    int r;
    logic [17:0] l;
    r = $urandom_range(0, 99);
    l = short_len ? 18'($urandom_range(0, 8)) : 18'($urandom);
    if (r < 30) send_fields(MODE_WRITE, 24'($urandom), l);
    else if (r < 75) send_fields(MODE_TICK, 24'($urandom), 18'($urandom));
    else if (r < 90) send_fields(MODE_READ, 24'($urandom), 18'($urandom));
    else send_fields(MODE_REQUEUE, 24'($urandom), 18'($urandom));
  endtask

  task automatic test_random_phase(int n);
    for (int i = 0; i < n; i++) send_random_item(1);
  endtask

  task automatic test_backpressure();
    drain_hold = 1'b1;
    hold_cycles = 400;
    for (int i = 0; i < 6; i++) send_fields(MODE_READ, 24'd0, 18'd0);
    while (dma_results.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    for (int i = 0; i < 20; i++) send_random_item(1);
  endtask

  initial begin
    cfg_clock = DAC_CLOCK_RST;
    cfg_rate = DAC_RATE_RST;
    cfg_frame = FRAME_TIME_RST;
    cfg_fps = FPS_RST;
    cfg_full_en = FULL_EN_RST;
    q_addr = '{default: '0};
    q_len = '{default: '0};
    q_dur = '{default: '0};
    busy = 0;
    full = 0;
    cd_active = 0;
    countdown = 0;
    last_len = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    set_config(27'd1000, 14'd0, 24'd3, 8'd2, 1'b1);
    test_random_phase(300);
    test_backpressure();
    set_config(27'($urandom_range(1, 100000)), 14'($urandom_range(0, 3)),
               24'($urandom_range(0, 50)), 8'($urandom_range(1, 255)), 1'b1);
    test_random_phase(300);
    set_config(27'd4000, 14'd1, 24'd10, 8'd1, 1'b0);
    test_random_phase(200);
    set_config(27'd3, 14'd0, 24'd1, 8'd1, 1'b1);
    test_random_phase(150);
    set_config(27'($urandom), 14'($urandom), 24'($urandom), 8'($urandom_range(1, 255)),
               1'b1);
    for (int i = 0; i < 200; i++) send_random_item(0);
    wait_idle();
    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (drain_hold && hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready <= 1'b0;
      if (hold_cycles == 1) drain_hold <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) < 70) || ($urandom_range(0, 9) == 0 ? 1'b0 : 1'b1);
    end
  end

  always @(posedge clk) begin
    out_t want;
    if (!rst && out_valid && out_ready) begin
      if (dma_results.size() == 0) begin
        $display("%0t unexpected result %h", $time, out_data);
        errors++;
      end else begin
        want = dma_results.pop_front();
        if (out_data !== want) begin
          $display("%0t mismatch expected %h actual %h", $time, want, out_data);
          errors++;
        end
      end
    end
  end

  initial begin
    #3000000;
    $display("Verification failed");
    $finish;
  end
endmodule
